/* rtl/mca_pkg.sv */
// Shared types and constants of the minimum-cost assignment block.
package mca_pkg;

  // Fixed field widths
  localparam int CostW = 16;
  localparam int IdxW  = 3;
  localparam int CfgW  = 4;
  localparam int OutW  = 19;

  // Worker count after reset
  localparam logic [CfgW-1:0] CFG_RESET = 4'd8;

  // Limits of the emitted cost
  localparam int OUT_MAX = 262143;
  localparam int OUT_MIN = -262144;

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_START,
    ST_RUN,
    ST_DRAIN,
    ST_WRITE,
    ST_DONE
  } state_e;

  // Commands from controller to datapath
  typedef struct packed {
    logic load;        // store the accepted cost entry
    logic start;       // seed the empty subset, restart the subset walk
    logic issue;       // read cost and subset entry for the current worker
    logic clr;         // forget the running minimum
    logic write_best;  // store the running minimum, advance the subset
    logic emit;        // load the output register
  } cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic w_last;      // current worker is the last one in use
    logic s_last;      // current subset is the full set
    logic n_zero;      // no workers in use
    logic out_busy;    // output register holds an item that is not taken
  } stat_t;

endpackage

/* rtl/mca_ctrl.sv */
// Sequencer of the minimum-cost assignment block.
module mca_ctrl import mca_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  input  logic  in_last_entry_i,
  input  stat_t stat_i,
  output logic  in_stall_o,
  output cmd_t  cmd_o
);

  state_e state_q, state_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          if (in_last_entry_i) begin
            state_d = ST_START;
          end
        end
      end
      ST_START: begin
        cmd_o.start = 1'b1;
        cmd_o.clr   = 1'b1;
        state_d     = stat_i.n_zero ? ST_DONE : ST_RUN;
      end
      ST_RUN: begin
        cmd_o.issue = 1'b1;
        if (stat_i.w_last) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_d = ST_WRITE;
      end
      ST_WRITE: begin
        cmd_o.write_best = 1'b1;
        cmd_o.clr        = 1'b1;
        state_d          = stat_i.s_last ? ST_DONE : ST_RUN;
      end
      ST_DONE: begin
        if (!stat_i.out_busy) begin
          cmd_o.emit = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

/* rtl/mca_datapath.sv */
// Cost store, subset table, minimum search and output register.
module mca_datapath import mca_pkg::*; #(
  parameter int MAX_WORKERS = 8
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_valid_i,
  input  logic [CfgW-1:0]        cfg_worker_count_i,
  input  logic [IdxW-1:0]        in_worker_i,
  input  logic [IdxW-1:0]        in_job_i,
  input  logic signed [CostW-1:0] in_cost_value_i,
  input  cmd_t                   cmd_i,
  output stat_t                  stat_o,
  input  logic                   out_stall_i,
  output logic                   out_valid_o,
  output logic signed [OutW-1:0] out_min_total_cost_o
);

  localparam int NW   = $clog2(MAX_WORKERS + 1);
  localparam int WW   = $clog2(MAX_WORKERS);
  localparam int CA   = $clog2(MAX_WORKERS * MAX_WORKERS);
  localparam int SD   = 1 << MAX_WORKERS;
  localparam int SumW = CostW + WW;
  localparam int SatW = (SumW > OutW) ? SumW : OutW;
  localparam logic [CA-1:0]          MaxCa = CA'(MAX_WORKERS);
  localparam logic [MAX_WORKERS-1:0] OneS  = MAX_WORKERS'(1);

  logic [CfgW-1:0]            cfg_q;
  logic [NW-1:0]              n_eff;
  logic [MAX_WORKERS-1:0]     full;
  logic [MAX_WORKERS-1:0]     s_q;
  logic [WW-1:0]              w_q;
  logic [WW-1:0]              job;
  logic [CA-1:0]              rd_addr;
  logic [CA-1:0]              ld_addr;
  logic                       ld_ok;
  logic [MAX_WORKERS-1:0]     bs_addr;
  logic [MAX_WORKERS-1:0]     wr_addr;
  logic signed [SumW-1:0]     wr_data;
  logic                       wr_en;
  logic signed [CostW-1:0]    cost_rd_q;
  logic signed [SumW-1:0]     best_rd_q;
  logic                       sel_q;
  logic                       have_q;
  logic signed [SumW-1:0]     best_q;
  logic signed [SumW-1:0]     cand;
  logic                       take;
  logic signed [SatW-1:0]     ext;
  logic signed [OutW-1:0]     sat;
  logic                       out_valid_q;
  logic signed [OutW-1:0]     out_cost_q;

  logic signed [CostW-1:0] cost_mem [MAX_WORKERS*MAX_WORKERS];
  logic signed [SumW-1:0]  best_mem [SD];

  function automatic logic [NW-1:0] popcnt(input logic [MAX_WORKERS-1:0] v);
    logic [NW-1:0] c;
    c = '0;
    for (int i = 0; i < MAX_WORKERS; i++) begin
      c = c + NW'(v[i]);
    end
    return c;
  endfunction

  // Hold the worker count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CFG_RESET;
    end else if (cfg_valid_i) begin
      cfg_q <= cfg_worker_count_i;
    end
  end

  // Clamp the worker count and form the full-set mask
  always_comb begin
    if (int'(cfg_q) > MAX_WORKERS) begin
      n_eff = NW'(MAX_WORKERS);
    end else begin
      n_eff = NW'(cfg_q);
    end
    for (int i = 0; i < MAX_WORKERS; i++) begin
      full[i] = (i < int'(n_eff));
    end
  end

  // Addresses
  assign job     = WW'(popcnt(s_q) - NW'(1));
  assign rd_addr = CA'(w_q) * MaxCa + CA'(job);
  assign ld_ok   = (int'(in_worker_i) < MAX_WORKERS) && (int'(in_job_i) < MAX_WORKERS);
  assign ld_addr = CA'(in_worker_i) * MaxCa + CA'(in_job_i);
  assign bs_addr = s_q & ~(OneS << w_q);

  // Cost store: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (cmd_i.load && ld_ok) begin
      cost_mem[ld_addr] <= in_cost_value_i;
    end
    cost_rd_q <= cost_mem[rd_addr];
  end

  // Subset table: seed the empty set or store a finished subset
  assign wr_en   = cmd_i.start || cmd_i.write_best;
  assign wr_addr = cmd_i.start ? '0 : s_q;
  assign wr_data = cmd_i.start ? '0 : best_q;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      best_mem[wr_addr] <= wr_data;
    end
    best_rd_q <= best_mem[bs_addr];
  end

  // Advance subset and worker counters, mark reads of workers in the subset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_q   <= '0;
      w_q   <= '0;
      sel_q <= 1'b0;
    end else begin
      sel_q <= cmd_i.issue && s_q[w_q];
      if (cmd_i.start) begin
        s_q <= OneS;
        w_q <= '0;
      end else if (cmd_i.issue) begin
        w_q <= w_q + WW'(1);
      end else if (cmd_i.write_best) begin
        s_q <= s_q + OneS;
        w_q <= '0;
      end
    end
  end

  // Compare candidate against running minimum
  assign cand = SumW'(cost_rd_q) + best_rd_q;
  assign take = sel_q && (!have_q || (cand < best_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      have_q <= 1'b0;
    end else if (cmd_i.clr) begin
      have_q <= 1'b0;
    end else if (take) begin
      have_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      best_q <= '0;
    end else if (take) begin
      best_q <= cand;
    end
  end

  // Saturate to the output range
  always_comb begin
    ext = SatW'(best_q);
    if (ext > SatW'(OUT_MAX)) begin
      sat = OutW'(OUT_MAX);
    end else if (ext < SatW'(OUT_MIN)) begin
      sat = OutW'(OUT_MIN);
    end else begin
      sat = OutW'(ext);
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_cost_q <= sat;
    end
  end

  assign out_valid_o          = out_valid_q;
  assign out_min_total_cost_o = out_cost_q;

  // Status
  assign stat_o.w_last   = (NW'(w_q) + NW'(1)) == n_eff;
  assign stat_o.s_last   = (s_q == full);
  assign stat_o.n_zero   = (n_eff == '0);
  assign stat_o.out_busy = out_valid_q && out_stall_i;

endmodule

/* rtl/min_cost_assignment_bitmask_dp.sv */
// Top level of the minimum-cost assignment block.
// Cost entries load one item per cycle, while idle, into a MAX_WORKERS x
// MAX_WORKERS store; an item with last_entry set is stored and then starts
// the solve, and input stalls until the result is in the output register. The
// solve walks subsets 1 .. 2^n-1 with one shared add-and-compare unit, one
// worker candidate per cycle from the registered reads of the cost store and
// the subset table. The user must write worker count n only while idle; the
// block does not enforce it. Values above MAX_WORKERS act as MAX_WORKERS, and
// zero gives a cost of 0. Entries with an index at or beyond MAX_WORKERS are
// dropped; unloaded entries read undefined.
module min_cost_assignment_bitmask_dp import mca_pkg::*; #(
  parameter int MAX_WORKERS = 8
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_valid_i,
  output logic                    cfg_ready_o,
  input  logic [CfgW-1:0]         cfg_worker_count_i,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic [IdxW-1:0]         in_worker_i,
  input  logic [IdxW-1:0]         in_job_i,
  input  logic signed [CostW-1:0] in_cost_value_i,
  input  logic                    in_last_entry_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic signed [OutW-1:0]  out_min_total_cost_o
);

  cmd_t  cmd;
  stat_t stat;

  assign cfg_ready_o = 1'b1;

  mca_ctrl u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_last_entry_i (in_last_entry_i),
    .stat_i          (stat),
    .in_stall_o      (in_stall_o),
    .cmd_o           (cmd)
  );

  mca_datapath #(
    .MAX_WORKERS (MAX_WORKERS)
  ) u_datapath (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .cfg_valid_i          (cfg_valid_i),
    .cfg_worker_count_i   (cfg_worker_count_i),
    .in_worker_i          (in_worker_i),
    .in_job_i             (in_job_i),
    .in_cost_value_i      (in_cost_value_i),
    .cmd_i                (cmd),
    .stat_o               (stat),
    .out_stall_i          (out_stall_i),
    .out_valid_o          (out_valid_o),
    .out_min_total_cost_o (out_min_total_cost_o)
  );

  // A last item starts a solve, so input stalls next cycle
  a_last_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && in_last_entry_i |=> in_stall_o)
    else $error("input not stalled after last item");

  // Never overwrite a result that is still waiting
  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.emit |-> !(out_valid_o && out_stall_i))
    else $error("result overwritten while stalled");

  // A new result only follows a solve
  a_out_after_solve: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result without a solve");

  // Reads and table writes never share a cycle
  a_no_issue_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.issue |-> !cmd.write_best && !cmd.start)
    else $error("issue overlaps table write");

endmodule
